// ----- design/fdr_pkg.sv -----
// ----------------------------------------------------------------------------
// fdr_pkg: shared types, constants and functions
// Field widths, register indexes, the frame record type and the gray
// conversion used by the frame difference ratio block.
// ----------------------------------------------------------------------------
package fdr_pkg;

  // field widths
  localparam int PIX_W   = 24;
  localparam int GRAY_W  = 8;
  localparam int CNT_W   = 25;
  localparam int RATIO_W = 17;
  localparam int DIM_W   = 13;
  localparam int IDX_W   = 8;
  localparam int DATA_W  = 13;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_RATIO_BITS = 16;

  // reset values of the registers
  localparam logic [GRAY_W-1:0] THRESH_RST = 8'd0;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;

  // register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 8'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 8'd2;

  // frame record queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [GRAY_W-1:0] threshold;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] diff_count;
    logic [CNT_W-1:0] pixel_count;
  } frame_rec_t;

  // bt.601 luma in integer form, result in 0..255
  function automatic logic [GRAY_W-1:0] to_gray(input logic [PIX_W-1:0] px);
    logic [22:0] sum;
    sum = 23'd1868 * 23'(px[7:0]) + 23'd9617 * 23'(px[15:8]) +
          23'd4899 * 23'(px[23:16]) + 23'd8192;
    return sum[21:14];
  endfunction

  // counter increment that holds at all ones
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/fdr_front.sv -----
// ----------------------------------------------------------------------------
// fdr_front: pixel intake and counting
// Converts both pixels to gray, flags differences above threshold, keeps
// the per-frame counters and pushes one record per frame into the queue.
// ----------------------------------------------------------------------------
module fdr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  fdr_pkg::cfg_t                     cfg,
  input  logic [fdr_pkg::PIX_W-1:0]         pixel_a,
  input  logic [fdr_pkg::PIX_W-1:0]         pixel_b,
  input  logic                              last_pixel,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fdr_pkg::FIFO_CNT_W-1:0]    fifo_count,
  output logic                              push,
  output fdr_pkg::frame_rec_t               push_rec
);

  logic [fdr_pkg::GRAY_W-1:0] gray_a;
  logic [fdr_pkg::GRAY_W-1:0] gray_b;
  logic [fdr_pkg::GRAY_W-1:0] gray_diff;
  logic                       s1_valid;
  logic                       s1_hit;
  logic                       s1_last;
  logic [fdr_pkg::CNT_W-1:0]  diff_counter;
  logic [fdr_pkg::CNT_W-1:0]  pixel_counter;
  logic [fdr_pkg::CNT_W-1:0]  diff_counter_next;
  logic [fdr_pkg::CNT_W-1:0]  pixel_counter_next;
  logic                       accept;

  // leave a queue slot for a record still in the first stage
  assign in_ready = (fifo_count + fdr_pkg::FIFO_CNT_W'(s1_valid))
                    < fdr_pkg::FIFO_CNT_W'(fdr_pkg::FIFO_DEPTH);
  assign accept   = in_valid && in_ready;

  // gray conversion and absolute difference
  assign gray_a    = fdr_pkg::to_gray(pixel_a);
  assign gray_b    = fdr_pkg::to_gray(pixel_b);
  assign gray_diff = (gray_a > gray_b) ? gray_a - gray_b : gray_b - gray_a;

  // stage one: classified pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_hit  <= gray_diff > cfg.threshold;
    s1_last <= last_pixel;
  end

  // stage two: counter update
  always_comb begin
    diff_counter_next  = s1_hit ? fdr_pkg::sat_inc(diff_counter) : diff_counter;
    pixel_counter_next = fdr_pkg::sat_inc(pixel_counter);
  end

  assign push                 = s1_valid && s1_last;
  assign push_rec.diff_count  = diff_counter_next;
  assign push_rec.pixel_count = pixel_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_counter  <= '0;
      pixel_counter <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        diff_counter  <= '0;
        pixel_counter <= '0;
      end else begin
        diff_counter  <= diff_counter_next;
        pixel_counter <= pixel_counter_next;
      end
    end
  end

endmodule

// ----- design/fdr_fifo.sv -----
// ----------------------------------------------------------------------------
// fdr_fifo: frame record queue
// Small register queue of finished frame counts between the counting
// front and the division back end.
// ----------------------------------------------------------------------------
module fdr_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  fdr_pkg::frame_rec_t            push_rec,
  input  logic                           pop,
  output fdr_pkg::frame_rec_t            head_rec,
  output logic                           empty,
  output logic [fdr_pkg::FIFO_CNT_W-1:0] count
);

  fdr_pkg::frame_rec_t                entries [fdr_pkg::FIFO_DEPTH];
  logic [fdr_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [fdr_pkg::FIFO_PTR_W-1:0]     rd_ptr;

  assign head_rec = entries[rd_ptr];
  assign empty    = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/fdr_back.sv -----
// ----------------------------------------------------------------------------
// fdr_back: ratio divider and result register
// Takes one frame record at a time, forms the fixed point ratio with a
// restoring divider one quotient bit per cycle, checks the frame size.
// ----------------------------------------------------------------------------
module fdr_back #(
  parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT,
  parameter int RATIO_BITS = fdr_pkg::DEF_RATIO_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fdr_pkg::cfg_t                   cfg,
  input  fdr_pkg::frame_rec_t             head_rec,
  input  logic                            empty,
  output logic                            pop,
  output logic [fdr_pkg::CNT_W-1:0]       diff_count,
  output logic [fdr_pkg::CNT_W-1:0]       pixel_count,
  output logic [fdr_pkg::RATIO_W-1:0]     diff_ratio,
  output logic                            size_error,
  output logic                            out_valid,
  input  logic                            out_ready
);

  localparam int QW    = RATIO_BITS + 1;
  localparam int QE    = (QW > fdr_pkg::RATIO_W) ? QW : fdr_pkg::RATIO_W;
  localparam int CW    = $clog2(QW);
  localparam int REM_W = fdr_pkg::CNT_W + 1;
  localparam int PROD_W = 2 * fdr_pkg::DIM_W;
  localparam int DIM_CMP_W = fdr_pkg::DIM_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                 state;
  logic [CW-1:0]              step_cnt;
  logic [REM_W-1:0]           rem;
  logic [fdr_pkg::CNT_W-1:0]  divisor;
  logic [fdr_pkg::CNT_W-1:0]  dcount;
  logic [QW-1:0]              quot;
  logic                       dim_bad;
  logic [PROD_W-1:0]          frame_size;
  logic                       ge;
  logic [REM_W-1:0]           rem_sub;
  logic [QW-1:0]              quot_next;
  logic [QE-1:0]              quot_ext;

  assign pop       = (state == ST_IDLE) && !empty;
  assign out_valid = (state == ST_OUT);

  // one restoring step
  always_comb begin
    ge        = rem >= REM_W'(divisor);
    rem_sub   = ge ? rem - REM_W'(divisor) : rem;
    quot_next = {quot[QW-2:0], ge};
    quot_ext  = QE'(quot_next);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath and result register
  always_ff @(posedge clk) begin
    if (pop) begin
      rem        <= REM_W'(head_rec.diff_count);
      divisor    <= head_rec.pixel_count;
      dcount     <= head_rec.diff_count;
      quot       <= '0;
      step_cnt   <= CW'(QW - 1);
      frame_size <= PROD_W'(cfg.width) * PROD_W'(cfg.height);
      dim_bad    <= (cfg.width == '0) || (cfg.height == '0) ||
                    (DIM_CMP_W'(cfg.width) > DIM_CMP_W'(MAX_WIDTH)) ||
                    (DIM_CMP_W'(cfg.height) > DIM_CMP_W'(MAX_HEIGHT));
    end else if (state == ST_DIV) begin
      rem      <= {rem_sub[REM_W-2:0], 1'b0};
      quot     <= quot_next;
      step_cnt <= step_cnt - 1'b1;
      if (step_cnt == '0) begin
        diff_count  <= dcount;
        pixel_count <= divisor;
        diff_ratio  <= (quot_ext > QE'(fdr_pkg::RATIO_MAX)) ?
                       fdr_pkg::RATIO_MAX : quot_ext[fdr_pkg::RATIO_W-1:0];
        size_error  <= dim_bad || (PROD_W'(divisor) != frame_size);
      end
    end
  end

endmodule

// ----- design/frame_difference_ratio.sv -----
// Path: a result follows its last pixel transfer through the classify register,
// the frame record queue and the ratio divider. Throughput: one pixel pair per
// cycle while in_ready is high; the divider takes one frame record at a time,
// with up to four frame records queued. Reset: threshold 0, width 640, height 480,
// counters and queue cleared.
// frame_difference_ratio: thresholded frame difference pixel count
// Counts pixel pairs whose gray difference exceeds a threshold and reports
// the counts, their fixed point ratio and a frame size check per frame.
// ----------------------------------------------------------------------------
module frame_difference_ratio #(
  parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT,
  parameter int RATIO_BITS = fdr_pkg::DEF_RATIO_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fdr_pkg::DATA_W-1:0]    cfg_data,
  input  logic [fdr_pkg::PIX_W-1:0]     pixel_a,
  input  logic [fdr_pkg::PIX_W-1:0]     pixel_b,
  input  logic                          last_pixel,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic [fdr_pkg::CNT_W-1:0]     diff_count,
  output logic [fdr_pkg::CNT_W-1:0]     pixel_count,
  output logic [fdr_pkg::RATIO_W-1:0]   diff_ratio,
  output logic                          size_error,
  output logic                          out_valid,
  input  logic                          out_ready
);

  fdr_pkg::cfg_t                    cfg;
  fdr_pkg::frame_rec_t              push_rec;
  fdr_pkg::frame_rec_t              head_rec;
  logic                             push;
  logic                             pop;
  logic                             empty;
  logic [fdr_pkg::FIFO_CNT_W-1:0]   fifo_count;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= fdr_pkg::THRESH_RST;
      cfg.width     <= fdr_pkg::WIDTH_RST;
      cfg.height    <= fdr_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdr_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[fdr_pkg::GRAY_W-1:0];
        fdr_pkg::REG_WIDTH:     cfg.width     <= cfg_data[fdr_pkg::DIM_W-1:0];
        fdr_pkg::REG_HEIGHT:    cfg.height    <= cfg_data[fdr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // intake and counting
  fdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel_a    (pixel_a),
    .pixel_b    (pixel_b),
    .last_pixel (last_pixel),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fifo_count (fifo_count),
    .push       (push),
    .push_rec   (push_rec)
  );

  // frame record queue
  fdr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (empty),
    .count    (fifo_count)
  );

  // ratio and size check
  fdr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .RATIO_BITS (RATIO_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_rec    (head_rec),
    .empty       (empty),
    .pop         (pop),
    .diff_count  (diff_count),
    .pixel_count (pixel_count),
    .diff_ratio  (diff_ratio),
    .size_error  (size_error),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

// ----- verif/tb_frame_difference_ratio.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_difference_ratio: frame difference ratio testbench
// Streams pixel pairs under several threshold and frame size settings,
// predicts each end-of-frame record (counts, Q1.16 ratio, size flag) and
// checks every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_frame_difference_ratio;
  import fdr_pkg::*;

  localparam int RATIO_BITS  = DEF_RATIO_BITS;
  localparam int MAX_WIDTH   = DEF_MAX_WIDTH;
  localparam int MAX_HEIGHT  = DEF_MAX_HEIGHT;
  localparam int DRAIN       = 2 * (RATIO_BITS + 4);
  localparam int PHASE_ITEMS = 128;
  localparam int IDLE_PCT    = 23;
  // index that no register decodes
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [CNT_W-1:0]   diff_count;
    logic [CNT_W-1:0]   pixel_count;
    logic [RATIO_W-1:0] ratio;
    logic               size_error;
  } frame_result_t;

  // frame record predictor and result checker
  class frame_scoreboard;
    logic [GRAY_W-1:0] threshold;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CNT_W-1:0]  diff_run;
    logic [CNT_W-1:0]  pixel_run;
    frame_result_t     awaited[$];
    int mismatches;
    int frames_seen;
    int size_errors;
    int pixels_seen;
    int reg_writes;

    function new();
      threshold   = THRESH_RST;
      width       = WIDTH_RST;
      height      = HEIGHT_RST;
      diff_run    = '0;
      pixel_run   = '0;
      mismatches  = 0;
      frames_seen = 0;
      size_errors = 0;
      pixels_seen = 0;
      reg_writes  = 0;
    endfunction

    function void write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_THRESHOLD: threshold = data[GRAY_W-1:0];
        REG_WIDTH:     width = data;
        REG_HEIGHT:    height = data;
        default: ;
      endcase
    endfunction

    // weighted luma, rounded, 0..255
    function int unsigned luma(input logic [PIX_W-1:0] px);
      int unsigned acc;
      acc = 1868 * int'(px[7:0]) + 9617 * int'(px[15:8]) + 4899 * int'(px[23:16]) + 8192;
      return acc >> 14;
    endfunction

    function void note_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                             input logic last);
      int unsigned ga;
      int unsigned gb;
      int unsigned gap;
      longint unsigned num;
      longint unsigned quot;
      frame_result_t res;
      ga = luma(a);
      gb = luma(b);
      gap = (ga > gb) ? ga - gb : gb - ga;
      pixels_seen++;
      // both counters hold at all ones
      if (gap > threshold && diff_run != CNT_MAX) diff_run++;
      if (pixel_run != CNT_MAX) pixel_run++;
      if (!last) return;
      num  = 64'(diff_run) << RATIO_BITS;
      quot = num / 64'(pixel_run);
      if (quot > 64'(RATIO_MAX)) quot = 64'(RATIO_MAX);
      res.diff_count  = diff_run;
      res.pixel_count = pixel_run;
      res.ratio       = quot[RATIO_W-1:0];
      res.size_error  = (width < 1) || (width > MAX_WIDTH) ||
                        (height < 1) || (height > MAX_HEIGHT) ||
                        (64'(pixel_run) != 64'(width) * 64'(height));
      awaited.push_back(res);
      diff_run  = '0;
      pixel_run = '0;
    endfunction

    function void compare(input string field, input logic [CNT_W-1:0] want,
                          input logic [CNT_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(input frame_result_t got);
      frame_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: frame record with none expected, actual diff %0d pixels %0d",
                 $time, got.diff_count, got.pixel_count);
        return;
      end
      want = awaited.pop_front();
      frames_seen++;
      if (want.size_error) size_errors++;
      compare("diff_count", want.diff_count, got.diff_count);
      compare("pixel_count", want.pixel_count, got.pixel_count);
      compare("diff_ratio", CNT_W'(want.ratio), CNT_W'(got.ratio));
      compare("size_error", CNT_W'(want.size_error), CNT_W'(got.size_error));
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index  = '0;
  logic [DATA_W-1:0]  cfg_data   = '0;
  logic [PIX_W-1:0]   pixel_a    = '0;
  logic [PIX_W-1:0]   pixel_b    = '0;
  logic               last_pixel = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [CNT_W-1:0]   diff_count;
  logic [CNT_W-1:0]   pixel_count;
  logic [RATIO_W-1:0] diff_ratio;
  logic               size_error;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  bit                 steady     = 1'b0;
  int                 settings   = 0;
  frame_scoreboard    ledger;

  frame_difference_ratio u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_a     (pixel_a),
    .pixel_b     (pixel_b),
    .last_pixel  (last_pixel),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .diff_count  (diff_count),
    .pixel_count (pixel_count),
    .diff_ratio  (diff_ratio),
    .size_error  (size_error),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // watch every transfer on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) ledger.note_pixel(pixel_a, pixel_b, last_pixel);
      if (out_valid && out_ready)
        ledger.check_result({diff_count, pixel_count, diff_ratio, size_error});
    end
  end

  // one pixel pair, returns at the edge of its transfer
  task automatic push_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                            input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pixel_a    <= a;
    pixel_b    <= b;
    last_pixel <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one register write, returns at the edge of its transfer
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for every frame record, then let the divider go quiet
  task automatic settle();
    @(posedge clk);
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] thr, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // random frames, mostly of the configured size when it is at most 64 pixels, ending on a last pixel
  task automatic run_phase(input logic [DATA_W-1:0] thr, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h, input int quota);
    int target;
    int len;
    int sent;
    int pick;
    logic [7:0] mask8;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    set_config(thr, w, h);
    target = int'(w) * int'(h);
    if (target > 64) target = 0;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (target == 0) len = $urandom_range(24, 1);
      else if (pick < 70) len = target;
      else if (pick < 85) len = ($urandom_range(1) == 1 || target == 1) ? target + 1 : target - 1;
      else len = $urandom_range(2 * target, 1);
      for (int i = 0; i < len; i++) begin
        a = PIX_W'($urandom);
        pick = $urandom_range(9);
        mask8 = 8'hFF >> $urandom_range(7);
        if (pick < 4) b = PIX_W'($urandom);
        else if (pick < 9) b = a ^ (PIX_W'($urandom) & {3{mask8}});
        else b = a;
        push_pixel(a, b, i == len - 1);
      end
      sent += len;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    ledger = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // extremes and each color weight alone, reset configuration
    push_pixel(24'h000000, 24'h000000, 1'b1);
    push_pixel(24'hFFFFFF, 24'h000000, 1'b1);
    push_pixel(24'h000000, 24'hFFFFFF, 1'b0);
    push_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    push_pixel(24'h0000FF, 24'h000000, 1'b0);
    push_pixel(24'h00FF00, 24'h000000, 1'b0);
    push_pixel(24'hFF0000, 24'h000000, 1'b1);
    // ratio truncation, two of three
    push_pixel(24'h000000, 24'h00FF00, 1'b0);
    push_pixel(24'h123456, 24'h123456, 1'b0);
    push_pixel(24'hAAAAAA, 24'h555555, 1'b1);
    in_valid <= 1'b0;

    // top threshold, single pixel frames that match the size
    set_config(13'd255, 13'd1, 13'd1);
    push_pixel(24'hFFFFFF, 24'h000000, 1'b1);
    push_pixel(24'h000000, 24'h000000, 1'b1);
    in_valid <= 1'b0;
    set_config(13'd254, 13'd1, 13'd1);
    push_pixel(24'hFFFFFF, 24'h000000, 1'b1);
    push_pixel(24'h555555, 24'hAAAAAA, 1'b1);
    in_valid <= 1'b0;

    // write to an index with no register behind it
    settle();
    write_reg(REG_UNUSED, DATA_W'($urandom));
    cfg_valid <= 1'b0;

    // random phases across sizes, thresholds and bad dimensions
    run_phase({5'($urandom), 8'($urandom_range(40))}, 13'd4, 13'd3, PHASE_ITEMS);
    run_phase(13'd0, 13'd1, 13'd1, PHASE_ITEMS);
    run_phase(13'd255, 13'd2, 13'd5, PHASE_ITEMS);
    steady = 1'b1;
    run_phase(DATA_W'($urandom_range(20)), 13'd8, 13'd8, PHASE_ITEMS);
    steady = 1'b0;
    run_phase({5'($urandom), 8'($urandom)}, 13'd4096, 13'd4096, PHASE_ITEMS);
    run_phase(DATA_W'($urandom_range(30)), 13'd0, 13'd7, PHASE_ITEMS);
    run_phase(DATA_W'($urandom_range(30)), 13'd5, 13'd0, PHASE_ITEMS);
    run_phase(13'h1FFF, 13'd8191, 13'd8191, PHASE_ITEMS);
    run_phase(13'd3, 13'd3, 13'd3, PHASE_ITEMS);
    run_phase(DATA_W'($urandom_range(60)), 13'd4097, 13'd1, PHASE_ITEMS);
    run_phase(DATA_W'($urandom_range(255)), DIM_W'($urandom_range(8, 1)),
              DIM_W'($urandom_range(8, 1)), PHASE_ITEMS);
    run_phase(DATA_W'($urandom_range(10)), DIM_W'($urandom_range(8, 1)),
              DIM_W'($urandom_range(8, 1)), PHASE_ITEMS);

    settle();
    $display("covered %0d pixel pairs in %0d frame records, %0d of them with a size error",
             ledger.pixels_seen, ledger.frames_seen, ledger.size_errors);
    $display("%0d register writes over %0d configurations", ledger.reg_writes, settings);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("tb_frame_difference_ratio OK");
    end else begin
      $display("tb_frame_difference_ratio NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("tb_frame_difference_ratio NOT OK");
    $finish;
  end

endmodule
